// ===== rtl/lfust_pkg.sv =====
// shared types and constants of the lfu slot table replacement core
// used by lfust_cell and lfu_slot_table_replacement_core; no dependencies
`default_nettype none

package lfust_pkg;

  localparam int SLOTS     = 16;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIM_W     = $clog2(SLOTS + 1);
  localparam int ID_W      = 16;
  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 5;
  localparam int SLOT_OUT_W = 4;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(16);
  localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_NEW          = CNT_W'(1);

  // search word that travels down the row of cells
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  hit_slot;
    logic              have_free;
    logic [IDX_W-1:0]  free_slot;
    logic [CNT_W-1:0]  best_cnt;
    logic [TIME_W-1:0] best_age;
    logic [IDX_W-1:0]  best_slot;
    logic [ID_W-1:0]   best_id;
  } scan_t;

  // update broadcast to all cells at the end of a scan
  typedef struct packed {
    logic             en;
    logic             touch;   // hit: bump count; else new entry at count 1
    logic [IDX_W-1:0] slot;
    logic [ID_W-1:0]  id;
  } wr_t;

endpackage

`default_nettype wire

// ===== rtl/lfust_cell.sv =====
// one table slot plus one stage of the search chain
// depends on lfust_pkg
`default_nettype none

module lfust_cell import lfust_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [IDX_W-1:0]  cell_idx_i,
  input  wire logic              in_range_i,
  input  wire logic [ID_W-1:0]   key_i,
  input  wire logic [TIME_W-1:0] now_i,
  input  wire logic              scan_valid_i,
  input  wire scan_t             scan_i,
  output logic                   scan_valid_o,
  output scan_t                  scan_o,
  input  wire wr_t               wr_i
);

  logic              valid_q;
  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [TIME_W-1:0] time_q;
  logic              scan_valid_q;
  scan_t             scan_q, scan_d;
  logic [TIME_W-1:0] age;
  logic              better;
  logic              wr_hit;

  assign age = now_i - time_q;
  // first slot seeds the victim search
  assign better = (cell_idx_i == '0) || (cnt_q < scan_i.best_cnt) ||
                  ((cnt_q == scan_i.best_cnt) && (age > scan_i.best_age));

  always_comb begin
    scan_d = scan_i;
    if (in_range_i) begin
      if (valid_q && (id_q == key_i) && !scan_i.found) begin
        scan_d.found    = 1'b1;
        scan_d.hit_slot = cell_idx_i;
      end
      if (!valid_q && !scan_i.have_free) begin
        scan_d.have_free = 1'b1;
        scan_d.free_slot = cell_idx_i;
      end
      if (better) begin
        scan_d.best_cnt  = cnt_q;
        scan_d.best_age  = age;
        scan_d.best_slot = cell_idx_i;
        scan_d.best_id   = id_q;
      end
    end
  end

  assign wr_hit = wr_i.en && (wr_i.slot == cell_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      scan_valid_q <= 1'b0;
    end else begin
      scan_valid_q <= scan_valid_i;
      if (wr_hit) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (wr_hit) begin
      id_q   <= wr_i.id;
      time_q <= now_i;
      if (!wr_i.touch) begin
        cnt_q <= CNT_NEW;
      end else if (cnt_q != CNT_MAX) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  assign scan_valid_o = scan_valid_q;
  assign scan_o       = scan_q;

endmodule

`default_nettype wire

// ===== rtl/lfu_slot_table_replacement_core.sv =====
// top level of the lfu slot table replacement core
// depends on lfust_pkg and lfust_cell
`default_nettype none

// lfu slot table with oldest-touch tie break. an id word is taken when
// start_i is high and busy_o is low. the id is searched through a row of
// SLOTS cells, one cell per cycle: a search word enters the first cell the
// cycle after start and moves one cell along each clock, collecting the hit,
// the lowest free slot and the victim (smallest count, then largest age,
// then lowest index). when it leaves the last cell the chosen slot is
// written and the result word appears on the outputs for exactly one cycle
// with done_o high; there is no backpressure, the receiver must take it.
// an item passes the start register, the cells and the result registers
// before done; busy_o drops in the cycle done_o is high so the next start
// can be taken there. only one item is in the chain at a time. the user
// writes slots_in_use via cfg_we_i/cfg_wdata_i only while the core is
// idle, not enforced by the core; 0 acts as 1, values above SLOTS as SLOTS.
// slots above the limit keep their contents and are skipped by the search.

module lfu_slot_table_replacement_core import lfust_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [ID_W-1:0]   entry_id_i,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  output logic                   done_o,
  output logic                   hit_o,
  output logic [SLOT_OUT_W-1:0]  slot_index_o,
  output logic                   evicted_valid_o,
  output logic [ID_W-1:0]        evicted_id_o
);

  // configuration and item state
  logic [CFG_W-1:0]  cfg_q;
  logic [TIME_W-1:0] now_q;
  logic [ID_W-1:0]   key_q;
  logic              busy_q;
  logic              inj_q;     // search word enters the first cell
  logic [LIM_W-1:0]  lim;
  logic [SLOTS-1:0]  in_range;

  // chain links: link k feeds cell k, link SLOTS leaves the last cell
  logic  [SLOTS:0] link_valid;
  scan_t           link [SLOTS+1];
  wr_t             wr;

  // result registers
  logic                  done_q;
  logic                  hit_q;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic                  ev_valid_q;
  logic [ID_W-1:0]       ev_id_q;

  logic                  accept;
  logic                  finish;
  scan_t                 fin;
  logic [IDX_W-1:0]      sel_slot;
  logic [IDX_W+SLOT_OUT_W-1:0] sel_wide;

  assign accept = start_i && !busy_q;

  // effective limit clamped to 1..SLOTS
  always_comb begin
    if (cfg_q == '0) begin
      lim = LIM_W'(1);
    end else if (int'(cfg_q) > SLOTS) begin
      lim = LIM_W'(SLOTS);
    end else begin
      lim = LIM_W'(cfg_q);
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_range[i] = (LIM_W'(i) < lim);
    end
  end

  // fresh search word
  assign link[0]       = '0;
  assign link_valid[0] = inj_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lfust_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cell_idx_i   (IDX_W'(g)),
      .in_range_i   (in_range[g]),
      .key_i        (key_q),
      .now_i        (now_q),
      .scan_valid_i (link_valid[g]),
      .scan_i       (link[g]),
      .scan_valid_o (link_valid[g+1]),
      .scan_o       (link[g+1]),
      .wr_i         (wr)
    );
  end

  // decision once the search word leaves the chain
  assign finish = link_valid[SLOTS];
  assign fin    = link[SLOTS];

  always_comb begin
    if (fin.found) begin
      sel_slot = fin.hit_slot;
    end else if (fin.have_free) begin
      sel_slot = fin.free_slot;
    end else begin
      sel_slot = fin.best_slot;
    end
    wr.en    = finish;
    wr.touch = fin.found;
    wr.slot  = sel_slot;
    wr.id    = key_q;
  end

  // slot number carried on its low bits only
  assign sel_wide = {{SLOT_OUT_W{1'b0}}, sel_slot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= SLOTS_IN_USE_RST;
      now_q  <= '0;
      busy_q <= 1'b0;
      inj_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      inj_q  <= accept;
      done_q <= finish;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        now_q <= now_q + TIME_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= entry_id_i;
    end
    if (finish) begin
      hit_q      <= fin.found;
      slot_q     <= sel_wide[SLOT_OUT_W-1:0];
      ev_valid_q <= !fin.found && !fin.have_free;
      ev_id_q    <= (!fin.found && !fin.have_free) ? fin.best_id : '0;
    end
  end

  // busy drops in the cycle the result is shown
  assign busy_o          = busy_q && !done_q;
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign slot_index_o    = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_id_o    = ev_id_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for lfu_slot_table_replacement_core
// depends on lfust_pkg and the core rtl; a directed table, then random phases
// over several slot limits, scored against an in-bench lfu table or typed words
`default_nettype none

module testbench import lfust_pkg::*;;

  // run length guard, several times a run with every gap at its longest
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHOW_MAX    = 10;
  localparam int POOL_LEN    = 24;
  localparam int PHASE_WORDS = 140;
  localparam int PLAN_LEN    = 25;
  localparam int FIFO_DEPTH  = 8;

  // one result word as the core reports it
  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  evicted_valid;
    logic [ID_W-1:0]       evicted_id;
  } lookup_res_t;

  // directed rows: a limit write, an id checked against the table model,
  // or an id whose result is typed in by hand
  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WORD,
    ROW_WORD_CHK
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [ID_W-1:0] value;
    lookup_res_t want;
  } row_t;

  localparam lookup_res_t NO_WANT = '0;

  // walk from reset: fill, hit, shrink to one slot (0 acts as 1), regrow with
  // 31 (acts as 16), force a duplicate id after shrink/regrow, then count and
  // age tie breaks, an over-range limit of 17 and lfu eviction at limit 4
  localparam row_t PLAN [PLAN_LEN] = '{
    '{ROW_WORD_CHK, 16'h0000, '{1'b0, 4'd0, 1'b0, 16'h0000}},
    '{ROW_WORD_CHK, 16'hFFFF, '{1'b0, 4'd1, 1'b0, 16'h0000}},
    '{ROW_WORD_CHK, 16'h0000, '{1'b1, 4'd0, 1'b0, 16'h0000}},
    '{ROW_CFG,      16'd0,    NO_WANT},
    '{ROW_WORD_CHK, 16'hFFFF, '{1'b0, 4'd0, 1'b1, 16'h0000}},
    '{ROW_WORD_CHK, 16'h5A5A, '{1'b0, 4'd0, 1'b1, 16'hFFFF}},
    '{ROW_CFG,      16'd31,   NO_WANT},
    '{ROW_WORD_CHK, 16'h5A5A, '{1'b1, 4'd0, 1'b0, 16'h0000}},
    '{ROW_WORD_CHK, 16'hFFFF, '{1'b1, 4'd1, 1'b0, 16'h0000}},
    '{ROW_CFG,      16'd1,    NO_WANT},
    '{ROW_WORD_CHK, 16'hFFFF, '{1'b0, 4'd0, 1'b1, 16'h5A5A}},
    '{ROW_CFG,      16'd2,    NO_WANT},
    '{ROW_WORD_CHK, 16'hFFFF, '{1'b1, 4'd0, 1'b0, 16'h0000}},
    '{ROW_WORD,     16'h1234, NO_WANT},
    '{ROW_CFG,      16'd17,   NO_WANT},
    '{ROW_WORD,     16'hA5A5, NO_WANT},
    '{ROW_WORD,     16'h1234, NO_WANT},
    '{ROW_WORD,     16'h8001, NO_WANT},
    '{ROW_WORD,     16'h7FFE, NO_WANT},
    '{ROW_WORD,     16'hA5A5, NO_WANT},
    '{ROW_CFG,      16'd4,    NO_WANT},
    '{ROW_WORD,     16'h0F0F, NO_WANT},
    '{ROW_WORD,     16'hF0F0, NO_WANT},
    '{ROW_WORD,     16'h0F0F, NO_WANT},
    '{ROW_CFG,      16'd16,   NO_WANT}
  };

  // limits visited by the random phases, extremes and over-range included
  localparam logic [CFG_W-1:0] PHASE_LIMITS [12] = '{
    5'd16, 5'd6, 5'd0, 5'd31, 5'd3, 5'd17, 5'd1, 5'd12, 5'd2, 5'd16, 5'd9, 5'd5
  };

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic [ID_W-1:0]       entry_id_i  = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  busy_o;
  logic                  done_o;
  logic                  hit_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic                  evicted_valid_o;
  logic [ID_W-1:0]       evicted_id_o;

  // in-bench copy of the slot table and its limit register
  bit                tbl_valid [SLOTS];
  bit [ID_W-1:0]     tbl_id    [SLOTS];
  bit [CNT_W-1:0]    tbl_cnt   [SLOTS];
  bit [TIME_W-1:0]   tbl_time  [SLOTS];
  bit [TIME_W-1:0]   item_no;
  bit [CFG_W-1:0]    limit_cfg = SLOTS_IN_USE_RST;

  // expected words in order of acceptance; writer and reader keep own counters
  lookup_res_t       exp_fifo [FIFO_DEPTH];
  int                exp_wr      = 0;
  int                exp_rd      = 0;
  logic [ID_W-1:0]   id_pool [POOL_LEN];
  int                bad_words   = 0;
  int                cycle_count = 0;

  lfu_slot_table_replacement_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .entry_id_i     (entry_id_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .slot_index_o   (slot_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_id_o   (evicted_id_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int pending_cnt();
    return exp_wr - exp_rd;
  endfunction

  // lfu lookup with oldest-touch tie break; updates the table copy and
  // returns the word the core should report for this id
  function automatic lookup_res_t lfu_lookup(input logic [ID_W-1:0] id);
    int              lim;
    int              s;
    int              free_s;
    int              i;
    bit              found;
    bit              have_free;
    bit [CNT_W-1:0]  best_cnt;
    bit [TIME_W-1:0] best_age;
    bit [TIME_W-1:0] age;
    lookup_res_t     r;
    // limit 0 behaves as 1, anything above SLOTS as SLOTS
    lim = (limit_cfg == 0) ? 1 : ((int'(limit_cfg) > SLOTS) ? SLOTS : int'(limit_cfg));
    r = '0;
    found = 1'b0;
    have_free = 1'b0;
    s = 0;
    free_s = 0;
    // lowest matching slot wins, so a duplicate left by a regrow is shadowed
    for (i = 0; i < lim; i++) begin
      if (tbl_valid[i] && tbl_id[i] == id && !found) begin
        found = 1'b1;
        s = i;
      end
      if (!tbl_valid[i] && !have_free) begin
        have_free = 1'b1;
        free_s = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (tbl_cnt[s] != CNT_MAX) tbl_cnt[s] = tbl_cnt[s] + 1'b1;
      tbl_time[s] = item_no;
    end else begin
      if (have_free) begin
        s = free_s;
      end else begin
        // victim: smallest count, then largest age (wrapping), then lowest slot
        best_cnt = tbl_cnt[0];
        best_age = item_no - tbl_time[0];
        s = 0;
        for (i = 1; i < lim; i++) begin
          age = item_no - tbl_time[i];
          if (tbl_cnt[i] < best_cnt || (tbl_cnt[i] == best_cnt && age > best_age)) begin
            best_cnt = tbl_cnt[i];
            best_age = age;
            s = i;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_id = tbl_id[s];
      end
      tbl_valid[s] = 1'b1;
      tbl_id[s] = id;
      tbl_cnt[s] = CNT_NEW;
      tbl_time[s] = item_no;
    end
    item_no = item_no + 1'b1;
    r.slot_index = SLOT_OUT_W'(s);
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // offer one id word and hold it until the core takes it; with gap 0 start
  // stays high so the next call can present its word in the same step
  task automatic send_word(input logic [ID_W-1:0] id, input int gap,
                           input bit typed, input lookup_res_t want);
    lookup_res_t model_res;
    start_i    <= 1'b1;
    entry_id_i <= id;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    model_res = lfu_lookup(id);
    exp_fifo[exp_wr % FIFO_DEPTH] = typed ? want : model_res;
    exp_wr++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // limit writes only happen with the core drained; every id yields a word,
  // so nothing pending plus busy low means nothing is in flight
  task automatic write_limit(input logic [CFG_W-1:0] v);
    while (pending_cnt() != 0 || busy_o !== 1'b0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    limit_cfg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result words have no backpressure: score each one on the edge that ends it
  always @(posedge clk_i) begin
    lookup_res_t got;
    lookup_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      got = '{hit_o, slot_index_o, evicted_valid_o, evicted_id_o};
      if (pending_cnt() == 0) begin
        bad_words++;
        if (bad_words <= SHOW_MAX)
          $display("unexpected result word: hit=%0b slot=%0d ev=%0b ev_id=%h",
                   got.hit, got.slot_index, got.evicted_valid, got.evicted_id);
      end else begin
        want = exp_fifo[exp_rd % FIFO_DEPTH];
        exp_rd++;
        if (got.hit !== want.hit || got.slot_index !== want.slot_index ||
            got.evicted_valid !== want.evicted_valid ||
            got.evicted_id !== want.evicted_id) begin
          bad_words++;
          if (bad_words <= SHOW_MAX)
            $display({"result mismatch: want hit=%0b slot=%0d ev=%0b ev_id=%h,",
                      " got hit=%0b slot=%0d ev=%0b ev_id=%h"},
                     want.hit, want.slot_index, want.evicted_valid, want.evicted_id,
                     got.hit, got.slot_index, got.evicted_valid, got.evicted_id);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending_cnt());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int              r;
    int              p;
    int              n;
    int              gap;
    bit              calm;
    logic [ID_W-1:0] id;
    for (n = 0; n < POOL_LEN; n++) id_pool[n] = ID_W'($urandom);

    // single reset at the start, released on a clock edge
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table; the word before a limit write and the last word drop
    // start so the write sees an idle core
    for (r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].kind == ROW_CFG) begin
        write_limit(PLAN[r].value[CFG_W-1:0]);
      end else begin
        gap = idle_len();
        if (r == PLAN_LEN - 1 || PLAN[r+1].kind == ROW_CFG) gap = gap + 1;
        send_word(PLAN[r].value, gap, PLAN[r].kind == ROW_WORD_CHK, PLAN[r].want);
      end
    end

    // random phases: mostly ids from a small pool so hits, refills and
    // evictions all happen, the rest fully random ids
    for (p = 0; p < $size(PHASE_LIMITS); p++) begin
      calm = ($urandom_range(3, 0) == 0);
      write_limit(PHASE_LIMITS[p]);
      for (n = 0; n < 4; n++) id_pool[$urandom_range(POOL_LEN - 1, 0)] = ID_W'($urandom);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99, 0) < 70) id = id_pool[$urandom_range(POOL_LEN - 1, 0)];
        else id = ID_W'($urandom);
        gap = calm ? 0 : idle_len();
        if (n == PHASE_WORDS - 1) gap = gap + 1;
        send_word(id, gap, 1'b0, NO_WANT);
      end
    end

    // drain, then give the scan chain time to show any stray word
    while (pending_cnt() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);

    if (bad_words == 0 && pending_cnt() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
